@@ rtl/core/crq_pkg.sv @@
// Shared types and constants of the coalescing request queue.
`default_nettype none

package crq_pkg;

    localparam int CRQ_DEPTH = 16;
    localparam int ID_W      = 16;
    localparam int LEVEL_W   = 8;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_POP_OUT
    } t_state;

    typedef struct packed {
        logic               func;
        logic [ID_W-1:0]    req_id;
        logic [LEVEL_W-1:0] req_level;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] level;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    out_id;
        logic [LEVEL_W-1:0] out_level;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/crq_in_if.sv @@
// Request channel: valid/ready handshake carrying one queue operation.
`default_nettype none

interface crq_in_if import crq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [ID_W-1:0]    req_id;
    logic [LEVEL_W-1:0] req_level;

    modport source (output valid, func, req_id, req_level, input ready);
    modport sink   (input valid, func, req_id, req_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/crq_out_if.sv @@
// Response channel: valid/ready handshake carrying one operation result.
`default_nettype none

interface crq_out_if import crq_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [ID_W-1:0]    out_id;
    logic [LEVEL_W-1:0] out_level;

    modport source (output valid, status, out_id, out_level, input ready);
    modport sink   (input valid, status, out_id, out_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/crq_store.sv @@
// Entry memory of the ring: one write port, one read port with registered data.
`default_nettype none

module crq_store import crq_pkg::*; #(
    parameter int DEPTH = CRQ_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire t_entry                   i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write entry, hold read data unless a read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/crq_ctrl.sv @@
// Sequencer: ring pointers, head-to-tail scan with one shared compare unit.
`default_nettype none

module crq_ctrl import crq_pkg::*; #(
    parameter int DEPTH = CRQ_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_cmd                     i_cmd,
    output      logic                     o_idle,
    input  wire logic                     i_out_free,
    output      logic                     o_done,
    output      t_result                  o_res,
    output      logic                     o_mem_we,
    output      logic [$clog2(DEPTH)-1:0] o_mem_waddr,
    output      t_entry                   o_mem_wdata,
    output      logic                     o_mem_re,
    output      logic [$clog2(DEPTH)-1:0] o_mem_raddr,
    input  wire t_entry                   i_mem_rdata
);

    localparam int PTR_W = $clog2(DEPTH);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, r_tail, r_scan, r_cmp_ptr;
    logic               r_cmp_vld;
    t_cmd               r_cmd;

    logic               w_hit, w_scan_end, w_full, w_empty;
    logic               w_issue, w_tail_adv, w_head_adv;
    logic [LEVEL_W-1:0] w_max_level;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Shared compare unit: id match on the word just read, and level maximum
    assign w_hit       = r_cmp_vld && (i_mem_rdata.id == r_cmd.req_id);
    assign w_max_level = (r_cmd.req_level > i_mem_rdata.level) ?
                         r_cmd.req_level : i_mem_rdata.level;
    assign w_scan_end  = (r_scan == r_tail);
    assign w_full      = (ring_next(r_tail) == r_head);
    assign w_empty     = (r_head == r_tail);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_cmd.func == FUNC_POP) ? S_POP_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if ((w_hit || w_scan_end) && i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP_RD: begin
                if (!w_empty) begin
                    n_state = S_POP_OUT;
                end else if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Outputs: memory access, result word, pointer moves
    always_comb begin
        o_idle      = 1'b0;
        o_done      = 1'b0;
        o_res       = '{status: ST_APPENDED, out_id: '0, out_level: '0};
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = '{id: r_cmd.req_id, level: r_cmd.req_level};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_scan;
        w_issue     = 1'b0;
        w_tail_adv  = 1'b0;
        w_head_adv  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
            end
            S_SCAN: begin
                if (w_hit) begin
                    // merge: raise level of the matching entry
                    o_done      = i_out_free;
                    o_res.status = ST_MERGED;
                    o_mem_we    = i_out_free;
                    o_mem_waddr = r_cmp_ptr;
                    o_mem_wdata = '{id: r_cmd.req_id, level: w_max_level};
                end else if (w_scan_end) begin
                    o_done = i_out_free;
                    if (w_full) begin
                        o_res.status = ST_DROPPED;
                    end else begin
                        o_res.status = ST_APPENDED;
                        o_mem_we     = i_out_free;
                        w_tail_adv   = i_out_free;
                    end
                end else begin
                    // advance scan: fetch next pending entry
                    o_mem_re = 1'b1;
                    w_issue  = 1'b1;
                end
            end
            S_POP_RD: begin
                if (w_empty) begin
                    o_done       = i_out_free;
                    o_res.status = ST_EMPTY;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_head;
                end
            end
            S_POP_OUT: begin
                o_done          = i_out_free;
                o_res.status    = ST_POPPED;
                o_res.out_id    = i_mem_rdata.id;
                o_res.out_level = i_mem_rdata.level;
                w_head_adv      = i_out_free;
            end
        endcase
    end

    // State and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_tail_adv) begin
                r_tail <= ring_next(r_tail);
            end
            if (w_head_adv) begin
                r_head <= ring_next(r_head);
            end
            if (r_state == S_IDLE && i_start) begin
                r_cmp_vld <= 1'b0;
            end else if (w_issue) begin
                r_cmp_vld <= 1'b1;
            end
        end
    end

    // Hold operation, step scan address
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd  <= i_cmd;
            r_scan <= r_head;
        end else if (w_issue) begin
            r_cmp_ptr <= r_scan;
            r_scan    <= ring_next(r_scan);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/coalescing_request_queue.sv @@
// Top level of the coalescing request queue: sequencer, entry memory, output register.
//
//  channel  dir  modport  word
//  i_req    in   sink     func, req_id, req_level
//  o_rsp    out  source   status, out_id, out_level
//
//  A push reads the pending entries from head to tail up to and including a match, or all
//  of them when none matches (at most DEPTH-1), one entry a cycle through the single read
//  port of the entry memory; a pop reads the head entry and then returns it, and on an
//  empty ring it returns the empty status without a read.
//  Reset clears the head and tail pointers; the ring starts empty, no clearing pass.
//  One result may wait in the output register while the next word is worked on;
//  a finished word waits in the sequencer until that register is free.
`default_nettype none

module coalescing_request_queue import crq_pkg::*; #(
    parameter int DEPTH = CRQ_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crq_in_if.sink    i_req,
    crq_out_if.source o_rsp
);

    localparam int PTR_W = $clog2(DEPTH);

    logic             w_idle, w_done, w_out_free;
    t_cmd             w_cmd;
    t_result          w_res;
    logic             w_we, w_re;
    logic [PTR_W-1:0] w_waddr, w_raddr;
    t_entry           w_wdata, w_rdata;

    logic             r_out_vld;
    t_result          r_out;

    assign w_cmd       = '{func: i_req.func, req_id: i_req.req_id,
                           req_level: i_req.req_level};
    assign i_req.ready = w_idle;
    assign w_out_free  = !r_out_vld || o_rsp.ready;

    crq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid && w_idle),
        .i_cmd       (w_cmd),
        .o_idle      (w_idle),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_res       (w_res),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_re    (w_re),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata)
    );

    crq_store #(.DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register: load finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.out_id    = r_out.out_id;
    assign o_rsp.out_level = r_out.out_level;

endmodule

`default_nettype wire
